FILE: rtl/point_mass_integrator_speed_limit_assert.svh
// assertion macros for the point mass integrator
`ifndef POINT_MASS_INTEGRATOR_SPEED_LIMIT_ASSERT_SVH
`define POINT_MASS_INTEGRATOR_SPEED_LIMIT_ASSERT_SVH

// implication checked on every clock edge outside reset
`define PMI_ASSERT_IMPL(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// implication checked in the cycle after the antecedent
`define PMI_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

FILE: rtl/pmi_pkg.sv
`timescale 1ns / 1ps
package pmi_pkg;
   localparam int unsigned CfgWidth    = 31;
   localparam int unsigned CfgIdxWidth = 2;
   localparam int unsigned DtWidth     = 24;
   localparam int unsigned HeadWidth   = 18;
   localparam int unsigned ValWidth    = 32;
   localparam int unsigned FracBits    = 16;
   localparam int unsigned RootBits    = 32;
   localparam logic [CfgWidth-1:0] MassReset  = 31'd65536;
   localparam logic [CfgWidth-1:0] SpeedReset = 31'd6553600;
   localparam logic [CfgWidth-1:0] LimitReset = 31'd65536000;
   localparam logic [63:0] EpsSq = 64'd429;
   localparam logic [HeadWidth-1:0] HeadOne = 18'd65536;

   localparam logic [CfgIdxWidth-1:0] RegMass  = 2'd0;
   localparam logic [CfgIdxWidth-1:0] RegSpeed = 2'd1;
   localparam logic [CfgIdxWidth-1:0] RegLimit = 2'd2;

   localparam logic [1:0] FuncStep    = 2'd0;
   localparam logic [1:0] FuncLoadPos = 2'd1;
   localparam logic [1:0] FuncLoadVel = 2'd2;

   // signed divide unit: 64-bit dividend magnitude, 32-bit divisor
   localparam int unsigned DivBits = 64;

   typedef enum logic [4:0] {
      ST_IDLE,
      ST_DV_MUL,
      ST_DV_DIV,
      ST_DV_ADD,
      ST_SQ1,
      ST_SQ_MUL,
      ST_CLAMP_TEST,
      ST_ROOT1,
      ST_ROOT_RUN,
      ST_CL_MUL,
      ST_CL_DIV,
      ST_CL_WR,
      ST_POS_MUL,
      ST_POS_ADD,
      ST_SQ2,
      ST_SQ2_MUL,
      ST_EPS_TEST,
      ST_ROOT2,
      ST_ROOT2_RUN,
      ST_HD_DIV,
      ST_HD_WR,
      ST_OUT
   } state_type;
endpackage

FILE: rtl/pmi_stream_if.sv
`timescale 1ns / 1ps
interface pmi_stream_if #(parameter int unsigned PayloadWidth = 8);
   logic valid;
   logic ready;
   logic [PayloadWidth-1:0] payload;
   modport source (output valid, output payload, input ready);
   modport sink (input valid, input payload, output ready);
endinterface

FILE: rtl/pmi_divider.sv
`timescale 1ns / 1ps
// restoring divider, one quotient bit per cycle, signed truncating
module pmi_divider
   import pmi_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   input  logic signed [63:0] dividend,
   input  logic [31:0]       divisor,
   output logic signed [63:0] quotient,
   output logic              done
);
   logic [DivBits-1:0] rem_ff, rem_in, quo_ff, quo_in;
   logic [6:0] cnt_ff, cnt_in;
   logic busy_ff, busy_in, neg_ff, neg_in, done_ff, done_in;
   logic [32:0] trial;
   logic [DivBits-1:0] mag;

   assign mag = dividend[63] ? (~dividend + 64'd1) : dividend;
   assign trial = {rem_ff[31:0], quo_ff[DivBits-1]} - {1'b0, divisor};

   always_comb begin
      rem_in = rem_ff; quo_in = quo_ff; cnt_in = cnt_ff;
      busy_in = busy_ff; neg_in = neg_ff; done_in = 1'b0;
      if (start) begin
         rem_in = '0; quo_in = mag; cnt_in = 7'(DivBits);
         busy_in = 1'b1; neg_in = dividend[63];
      end else if (busy_ff) begin
         if (!trial[32]) begin
            rem_in = {32'd0, trial[31:0]};
            quo_in = {quo_ff[DivBits-2:0], 1'b1};
         end else begin
            rem_in = {rem_ff[DivBits-2:0], quo_ff[DivBits-1]};
            quo_in = {quo_ff[DivBits-2:0], 1'b0};
         end
         cnt_in = cnt_ff - 7'd1;
         if (cnt_ff == 7'd1) begin
            busy_in = 1'b0; done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0; done_ff <= 1'b0; cnt_ff <= '0;
      end else begin
         busy_ff <= busy_in; done_ff <= done_in; cnt_ff <= cnt_in;
      end
      rem_ff <= rem_in; quo_ff <= quo_in; neg_ff <= neg_in;
   end

   assign quotient = neg_ff ? (~quo_ff + 64'd1) : quo_ff;
   assign done = done_ff;
endmodule

FILE: rtl/pmi_sqrt.sv
`timescale 1ns / 1ps
// bit-pair integer square root, one result bit per cycle
module pmi_sqrt
   import pmi_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   input  logic [63:0] radicand,
   output logic [RootBits-1:0] root,
   output logic        done
);
   logic [63:0] n_ff, n_in, r_ff, r_in, b_ff, b_in;
   logic busy_ff, busy_in, done_ff, done_in;
   logic [63:0] rb;

   assign rb = r_ff + b_ff;

   always_comb begin
      n_in = n_ff; r_in = r_ff; b_in = b_ff; busy_in = busy_ff; done_in = 1'b0;
      if (start) begin
         n_in = radicand; r_in = '0; b_in = 64'h4000_0000_0000_0000; busy_in = 1'b1;
      end else if (busy_ff) begin
         if (n_ff >= rb) begin
            n_in = n_ff - rb;
            r_in = (r_ff >> 1) + b_ff;
         end else begin
            r_in = r_ff >> 1;
         end
         b_in = b_ff >> 2;
         if (b_ff[0]) begin
            busy_in = 1'b0; done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0; done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in; done_ff <= done_in;
      end
      n_ff <= n_in; r_ff <= r_in; b_ff <= b_in;
   end

   assign root = r_ff[RootBits-1:0];
   assign done = done_ff;
endmodule

FILE: rtl/point_mass_integrator_speed_limit.sv
`timescale 1ns / 1ps
// Point mass integrator with speed limit. Each request beat carries func, a force or
// load vector and dt; each produces exactly one response beat with position, velocity,
// heading and the clamp/wrap flags. A load or an unused func code is answered in the
// cycle after acceptance; a new request is taken only once that response has left. A
// step runs the three axes through one shared multiplier, one 64-bit restoring
// divider and one square root: three force divides, then, when the speed is over the
// limit, one root and three rescale divides, three position updates, and, when the
// speed is above epsilon, one root and three heading divides. req_ready is low from
// acceptance until the response beat is taken.
module point_mass_integrator_speed_limit
   import pmi_pkg::*;
(
   input  logic clock,
   input  logic reset,
   input  logic csr_we,
   input  logic [CfgIdxWidth-1:0] csr_index,
   input  logic [CfgWidth-1:0] csr_wdata,
   input  logic req_valid,
   output logic req_ready,
   input  logic [1:0] req_func,
   input  logic signed [31:0] req_vec_x,
   input  logic signed [31:0] req_vec_y,
   input  logic signed [31:0] req_vec_z,
   input  logic [DtWidth-1:0] req_dt,
   output logic rsp_valid,
   input  logic rsp_ready,
   output logic signed [31:0] rsp_pos_x,
   output logic signed [31:0] rsp_pos_y,
   output logic signed [31:0] rsp_pos_z,
   output logic signed [31:0] rsp_vel_x,
   output logic signed [31:0] rsp_vel_y,
   output logic signed [31:0] rsp_vel_z,
   output logic signed [HeadWidth-1:0] rsp_head_x,
   output logic signed [HeadWidth-1:0] rsp_head_y,
   output logic signed [HeadWidth-1:0] rsp_head_z,
   output logic rsp_speed_clamped,
   output logic rsp_wrapped
);
   `include "point_mass_integrator_speed_limit_assert.svh"

   // config registers
   logic [CfgWidth-1:0] mass_ff, speed_ff, limit_ff;
   always_ff @(posedge clock) begin
      if (reset) begin
         mass_ff <= MassReset; speed_ff <= SpeedReset; limit_ff <= LimitReset;
      end else if (csr_we) begin
         unique case (csr_index)
            RegMass:  mass_ff  <= csr_wdata;
            RegSpeed: speed_ff <= csr_wdata;
            RegLimit: limit_ff <= csr_wdata;
            default: ;
         endcase
      end
   end

   // architectural state
   logic signed [31:0] pos_ff [3];
   logic signed [31:0] vel_ff [3];
   logic signed [HeadWidth-1:0] head_ff [3];
   logic signed [31:0] vec_ff [3];
   logic [DtWidth-1:0] dt_ff;
   logic clamp_ff, wrap_ff;
   logic [1:0] axis_ff;
   logic [63:0] acc_ff;           // squared speed accumulator
   logic signed [63:0] prod_ff;   // shared multiplier output register
   logic [RootBits-1:0] len_ff;
   state_type state_ff, state_in;

   // one shared signed multiplier, 33 x 33 bits
   logic signed [32:0] mul_a, mul_b;
   logic signed [65:0] mul_p;
   assign mul_p = mul_a * mul_b;

   logic div_start, div_done, sqrt_start, sqrt_done;
   logic signed [63:0] div_q;
   logic [31:0] div_d;
   logic [RootBits-1:0] root;

   pmi_divider u_div (.clock, .reset, .start(div_start), .dividend(prod_ff),
      .divisor(div_d), .quotient(div_q), .done(div_done));
   pmi_sqrt u_sqrt (.clock, .reset, .start(sqrt_start), .radicand(acc_ff),
      .root(root), .done(sqrt_done));

   logic last_axis;
   assign last_axis = (axis_ff == 2'd2);

   // divisor selection
   always_comb begin
      unique case (state_ff)
         ST_DV_MUL, ST_DV_DIV: div_d = (mass_ff == '0) ? 32'd1 : {1'b0, mass_ff};
         ST_CL_MUL, ST_CL_DIV: div_d = len_ff;
         default:              div_d = len_ff;
      endcase
   end

   // multiplier operands
   always_comb begin
      mul_a = 33'(vel_ff[axis_ff]);
      mul_b = 33'(vel_ff[axis_ff]);
      unique case (state_ff)
         ST_DV_MUL: begin mul_a = 33'(vec_ff[axis_ff]); mul_b = {9'd0, dt_ff}; end
         ST_CL_MUL: mul_b = {2'b00, speed_ff};
         ST_POS_MUL: mul_b = {9'd0, dt_ff};
         // speed limit squared for the clamp test
         ST_CLAMP_TEST: begin mul_a = {2'b00, speed_ff}; mul_b = {2'b00, speed_ff}; end
         default: ;
      endcase
   end

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: if (req_valid) begin
            state_in = (req_func == FuncStep) ? ST_DV_MUL : ST_OUT;
         end
         ST_DV_MUL: state_in = ST_DV_DIV;
         ST_DV_DIV: if (div_done) state_in = ST_DV_ADD;
         ST_DV_ADD: state_in = last_axis ? ST_SQ1 : ST_DV_MUL;
         ST_SQ1: state_in = ST_SQ_MUL;
         ST_SQ_MUL: state_in = last_axis ? ST_CLAMP_TEST : ST_SQ1;
         ST_CLAMP_TEST: state_in = (acc_ff > mul_p[63:0]) ? ST_ROOT1 : ST_POS_MUL;
         ST_ROOT1: state_in = ST_ROOT_RUN;
         ST_ROOT_RUN: if (sqrt_done) state_in = ST_CL_MUL;
         ST_CL_MUL: state_in = ST_CL_DIV;
         ST_CL_DIV: if (div_done) state_in = ST_CL_WR;
         ST_CL_WR: state_in = last_axis ? ST_POS_MUL : ST_CL_MUL;
         ST_POS_MUL: state_in = ST_POS_ADD;
         ST_POS_ADD: state_in = last_axis ? ST_SQ2 : ST_POS_MUL;
         ST_SQ2: state_in = ST_SQ2_MUL;
         ST_SQ2_MUL: state_in = last_axis ? ST_EPS_TEST : ST_SQ2;
         ST_EPS_TEST: state_in = (acc_ff > EpsSq) ? ST_ROOT2 : ST_OUT;
         ST_ROOT2: state_in = ST_ROOT2_RUN;
         ST_ROOT2_RUN: if (sqrt_done) state_in = ST_HD_DIV;
         ST_HD_DIV: if (div_done) state_in = ST_HD_WR;
         ST_HD_WR: state_in = last_axis ? ST_OUT : ST_HD_DIV;
         ST_OUT: if (rsp_ready) state_in = ST_IDLE;
         default: state_in = ST_IDLE;
      endcase
   end

   // control outputs
   logic div_go_ff;
   always_comb begin
      req_ready = (state_ff == ST_IDLE);
      rsp_valid = (state_ff == ST_OUT);
      div_start = div_go_ff;
      sqrt_start = (state_ff == ST_ROOT1) || (state_ff == ST_ROOT2);
   end

   // datapath
   logic signed [63:0] vsum, psum;
   logic signed [33:0] lim_s;
   assign vsum = 64'(vel_ff[axis_ff]) + div_q;
   assign psum = 64'(pos_ff[axis_ff]) + (prod_ff >>> FracBits)
      + 64'((prod_ff[63] && (prod_ff[FracBits-1:0] != '0)) ? 1 : 0);
   assign lim_s = 34'(limit_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE; div_go_ff <= 1'b0;
         for (int i = 0; i < 3; i++) begin
            pos_ff[i] <= '0; vel_ff[i] <= '0;
            head_ff[i] <= (i == 2) ? HeadOne : '0;
         end
         clamp_ff <= 1'b0; wrap_ff <= 1'b0; axis_ff <= '0;
      end else begin
         state_ff <= state_in;
         div_go_ff <= 1'b0;
         unique case (state_ff)
            ST_IDLE: if (req_valid) begin
               vec_ff[0] <= req_vec_x; vec_ff[1] <= req_vec_y; vec_ff[2] <= req_vec_z;
               dt_ff <= req_dt; clamp_ff <= 1'b0; wrap_ff <= 1'b0; axis_ff <= '0;
               acc_ff <= '0;
               if (req_func == FuncLoadPos) begin
                  pos_ff[0] <= req_vec_x; pos_ff[1] <= req_vec_y; pos_ff[2] <= req_vec_z;
               end else if (req_func == FuncLoadVel) begin
                  vel_ff[0] <= req_vec_x; vel_ff[1] <= req_vec_y; vel_ff[2] <= req_vec_z;
               end
            end
            ST_DV_MUL, ST_CL_MUL: begin
               prod_ff <= mul_p[63:0]; div_go_ff <= 1'b1;
            end
            ST_DV_ADD: begin
               if (vsum > 64'sh7FFF_FFFF) vel_ff[axis_ff] <= 32'sh7FFF_FFFF;
               else if (vsum < -64'sh8000_0000) vel_ff[axis_ff] <= 32'sh8000_0000;
               else vel_ff[axis_ff] <= vsum[31:0];
               axis_ff <= last_axis ? 2'd0 : axis_ff + 2'd1;
            end
            ST_SQ1, ST_SQ2: prod_ff <= mul_p[63:0];
            ST_SQ_MUL, ST_SQ2_MUL: begin
               acc_ff <= acc_ff + prod_ff;
               axis_ff <= last_axis ? 2'd0 : axis_ff + 2'd1;
            end
            ST_ROOT_RUN, ST_ROOT2_RUN: if (sqrt_done) begin
               len_ff <= root;
               if (state_ff == ST_ROOT2_RUN) begin
                  prod_ff <= 64'(vel_ff[0]) <<< FracBits; div_go_ff <= 1'b1;
               end
            end
            ST_CLAMP_TEST: if (state_in == ST_ROOT1) clamp_ff <= 1'b1;
            ST_CL_WR: begin
               vel_ff[axis_ff] <= div_q[31:0];
               axis_ff <= last_axis ? 2'd0 : axis_ff + 2'd1;
            end
            ST_POS_MUL: prod_ff <= mul_p[63:0];
            ST_POS_ADD: begin
               if (psum > 64'(lim_s)) begin
                  pos_ff[axis_ff] <= 32'(-lim_s); wrap_ff <= 1'b1;
               end else if (psum < -64'(lim_s)) begin
                  pos_ff[axis_ff] <= 32'(lim_s); wrap_ff <= 1'b1;
               end else pos_ff[axis_ff] <= psum[31:0];
               axis_ff <= last_axis ? 2'd0 : axis_ff + 2'd1;
               if (last_axis) acc_ff <= '0;
            end
            ST_HD_WR: begin
               head_ff[axis_ff] <= div_q[HeadWidth-1:0];
               if (!last_axis) begin
                  prod_ff <= 64'(vel_ff[axis_ff + 2'd1]) <<< FracBits;
                  div_go_ff <= 1'b1;
               end
               axis_ff <= last_axis ? 2'd0 : axis_ff + 2'd1;
            end
            ST_EPS_TEST: axis_ff <= '0;
            default: ;
         endcase
      end
   end

   // response payload straight from state
   assign rsp_pos_x = pos_ff[0];
   assign rsp_pos_y = pos_ff[1];
   assign rsp_pos_z = pos_ff[2];
   assign rsp_vel_x = vel_ff[0];
   assign rsp_vel_y = vel_ff[1];
   assign rsp_vel_z = vel_ff[2];
   assign rsp_head_x = head_ff[0];
   assign rsp_head_y = head_ff[1];
   assign rsp_head_z = head_ff[2];
   assign rsp_speed_clamped = clamp_ff;
   assign rsp_wrapped = wrap_ff;

   `PMI_ASSERT_IMPL(a_one_side, clock, reset, rsp_valid, !req_ready,
      "request taken while response pending")
   `PMI_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready, rsp_valid,
      "response dropped before taken")
   `PMI_ASSERT_IMPL(a_load_flags, clock, reset,
      req_valid && req_ready && (req_func != FuncStep), state_in == ST_OUT,
      "load must answer directly")
endmodule

FILE: dv/tb_point_mass_integrator_speed_limit.sv
`timescale 1ns / 1ps
module tb_point_mass_integrator_speed_limit;
   import pmi_pkg::*;

   // func code with no defined operation: the state is only reported
   localparam logic [1:0] FuncNone = 2'd3;
   localparam int unsigned ReqWidth = 2 + 3 * ValWidth + DtWidth;
   localparam int unsigned RspWidth = 6 * ValWidth + 3 * HeadWidth + 2;
   localparam int unsigned SettleCycles = 16;

   typedef struct packed {
      logic [1:0] func;
      logic signed [31:0] vec_x;
      logic signed [31:0] vec_y;
      logic signed [31:0] vec_z;
      logic [DtWidth-1:0] dt;
   } motion_req_type;

   typedef struct packed {
      logic signed [31:0] pos_x;
      logic signed [31:0] pos_y;
      logic signed [31:0] pos_z;
      logic signed [31:0] vel_x;
      logic signed [31:0] vel_y;
      logic signed [31:0] vel_z;
      logic signed [HeadWidth-1:0] head_x;
      logic signed [HeadWidth-1:0] head_y;
      logic signed [HeadWidth-1:0] head_z;
      logic speed_clamped;
      logic wrapped;
   } motion_rsp_type;

   // integrator model: own copy of the vehicle state and the registers,
   // expected beats queued in order of acceptance
   class motion_scoreboard;
      longint signed pos[3];
      longint signed vel[3];
      longint signed head[3];
      longint unsigned mass;
      longint unsigned speed_limit;
      longint unsigned world_limit;
      motion_rsp_type expected_beats[$];
      int unsigned errors;
      int unsigned steps_seen, clamps_seen, wraps_seen, loads_seen;

      function new();
         for (int i = 0; i < 3; i++) begin
            pos[i] = 0;
            vel[i] = 0;
            head[i] = 0;
         end
         head[2] = 65536;
         mass = MassReset;
         speed_limit = SpeedReset;
         world_limit = LimitReset;
      endfunction

      function void write_reg(logic [CfgIdxWidth-1:0] idx, logic [CfgWidth-1:0] value);
         case (idx)
            RegMass:  mass = value;
            RegSpeed: speed_limit = value;
            RegLimit: world_limit = value;
            default: ;
         endcase
      endfunction

      function longint unsigned int_sqrt(longint unsigned n);
         longint unsigned r, b;
         r = 0;
         b = 64'd1 << 62;
         while (b > n) b = b >> 2;
         while (b != 0) begin
            if (n >= r + b) begin
               n = n - (r + b);
               r = (r >> 1) + b;
            end else begin
               r = r >> 1;
            end
            b = b >> 2;
         end
         return r;
      endfunction

      function longint unsigned speed_squared();
         longint unsigned s, a;
         s = 0;
         for (int i = 0; i < 3; i++) begin
            a = (vel[i] < 0) ? -vel[i] : vel[i];
            s += a * a;
         end
         return s;
      endfunction

      function void note_request(motion_req_type r);
         longint signed vec[3];
         longint signed m, lim, len, p, dt, v;
         longint unsigned s;
         logic clamped, wrapped;
         motion_rsp_type e;
         vec[0] = r.vec_x;
         vec[1] = r.vec_y;
         vec[2] = r.vec_z;
         dt = r.dt;
         clamped = 0;
         wrapped = 0;
         if (r.func == FuncLoadPos) begin
            for (int i = 0; i < 3; i++) pos[i] = vec[i];
            loads_seen++;
         end else if (r.func == FuncLoadVel) begin
            for (int i = 0; i < 3; i++) vel[i] = vec[i];
            loads_seen++;
         end else if (r.func == FuncStep) begin
            steps_seen++;
            // zero mass acts as the smallest unit
            m = (mass == 0) ? 1 : mass;
            lim = world_limit;
            for (int i = 0; i < 3; i++) begin
               v = vel[i] + (vec[i] * dt) / m;
               if (v > 64'sh7FFFFFFF) v = 64'sh7FFFFFFF;
               if (v < -64'sh80000000) v = -64'sh80000000;
               vel[i] = v;
            end
            s = speed_squared();
            if (s > speed_limit * speed_limit) begin
               len = int_sqrt(s);
               clamped = 1;
               for (int i = 0; i < 3; i++) vel[i] = (vel[i] * longint'(speed_limit)) / len;
            end
            // leaving the cube lands on the opposite face, not modular
            for (int i = 0; i < 3; i++) begin
               p = pos[i] + (vel[i] * dt) / 65536;
               if (p > lim) begin
                  p = -lim;
                  wrapped = 1;
               end else if (p < -lim) begin
                  p = lim;
                  wrapped = 1;
               end
               pos[i] = p;
            end
            s = speed_squared();
            if (s > EpsSq) begin
               len = int_sqrt(s);
               for (int i = 0; i < 3; i++) head[i] = (vel[i] * 65536) / len;
            end
            clamps_seen += clamped;
            wraps_seen += wrapped;
         end
         e.pos_x = pos[0];
         e.pos_y = pos[1];
         e.pos_z = pos[2];
         e.vel_x = vel[0];
         e.vel_y = vel[1];
         e.vel_z = vel[2];
         e.head_x = head[0];
         e.head_y = head[1];
         e.head_z = head[2];
         e.speed_clamped = clamped;
         e.wrapped = wrapped;
         expected_beats.push_back(e);
      endfunction

      task report(string what, longint got, longint want);
         errors++;
         $display("%0t mismatch %s: got %0d want %0d", $realtime, what, got, want);
      endtask

      task check_field(string what, longint got, longint want);
         if (got != want) report(what, got, want);
      endtask

      task check_response(motion_rsp_type g);
         motion_rsp_type e;
         if (expected_beats.size() == 0) begin
            report("unexpected response beat", 0, 0);
            return;
         end
         e = expected_beats.pop_front();
         check_field("pos_x", g.pos_x, e.pos_x);
         check_field("pos_y", g.pos_y, e.pos_y);
         check_field("pos_z", g.pos_z, e.pos_z);
         check_field("vel_x", g.vel_x, e.vel_x);
         check_field("vel_y", g.vel_y, e.vel_y);
         check_field("vel_z", g.vel_z, e.vel_z);
         check_field("head_x", g.head_x, e.head_x);
         check_field("head_y", g.head_y, e.head_y);
         check_field("head_z", g.head_z, e.head_z);
         check_field("speed_clamped", g.speed_clamped, e.speed_clamped);
         check_field("wrapped", g.wrapped, e.wrapped);
      endtask
   endclass

   logic clock;
   logic reset;
   logic csr_we;
   logic [CfgIdxWidth-1:0] csr_index;
   logic [CfgWidth-1:0] csr_wdata;

   pmi_stream_if #(.PayloadWidth(ReqWidth)) req_ch ();
   pmi_stream_if #(.PayloadWidth(RspWidth)) rsp_ch ();

   motion_req_type req_beat;
   motion_rsp_type rsp_beat;
   assign req_beat = req_ch.payload;

   point_mass_integrator_speed_limit i_dut (
      .clock(clock),
      .reset(reset),
      .csr_we(csr_we),
      .csr_index(csr_index),
      .csr_wdata(csr_wdata),
      .req_valid(req_ch.valid),
      .req_ready(req_ch.ready),
      .req_func(req_beat.func),
      .req_vec_x(req_beat.vec_x),
      .req_vec_y(req_beat.vec_y),
      .req_vec_z(req_beat.vec_z),
      .req_dt(req_beat.dt),
      .rsp_valid(rsp_ch.valid),
      .rsp_ready(rsp_ch.ready),
      .rsp_pos_x(rsp_beat.pos_x),
      .rsp_pos_y(rsp_beat.pos_y),
      .rsp_pos_z(rsp_beat.pos_z),
      .rsp_vel_x(rsp_beat.vel_x),
      .rsp_vel_y(rsp_beat.vel_y),
      .rsp_vel_z(rsp_beat.vel_z),
      .rsp_head_x(rsp_beat.head_x),
      .rsp_head_y(rsp_beat.head_y),
      .rsp_head_z(rsp_beat.head_z),
      .rsp_speed_clamped(rsp_beat.speed_clamped),
      .rsp_wrapped(rsp_beat.wrapped)
   );
   assign rsp_ch.payload = rsp_beat;

   motion_scoreboard board = new();

   // 8 ns clock
   always begin
      clock = 1'b0;
      #4;
      clock = 1'b1;
      #4;
   end

   // both sides are watched at the same edge; the block holds req_ready low
   // until the response beat is taken, so notes always precede checks
   always @(posedge clock) begin
      if (!reset) begin
         if (req_ch.valid && req_ch.ready) board.note_request(req_beat);
         if (rsp_ch.valid && rsp_ch.ready) board.check_response(rsp_beat);
      end
   end

   // receiver stall pattern: runs of always-ready alternate with runs of
   // random back-pressure of varying density
   int unsigned stall_run;
   int unsigned stall_pct;
   always @(posedge clock) begin
      if (stall_run == 0) begin
         stall_run <= $urandom_range(20, 400);
         stall_pct <= ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(10, 90);
      end else begin
         stall_run <= stall_run - 1;
      end
      rsp_ch.ready <= reset ? 1'b0 : ($urandom_range(0, 99) >= stall_pct);
   end

   // sender burst state
   int unsigned burst_left;
   int unsigned items_sent;

   // write enable stays up across back-to-back writes; the caller drops it
   task automatic write_reg(logic [CfgIdxWidth-1:0] idx, logic [CfgWidth-1:0] value);
      csr_we <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      @(posedge clock);
      board.write_reg(idx, value);
   endtask

   // registers only change with nothing in flight
   task automatic wait_idle();
      while (board.expected_beats.size() != 0) @(posedge clock);
      repeat (SettleCycles) @(posedge clock);
   endtask

   task automatic configure(logic [CfgWidth-1:0] m, logic [CfgWidth-1:0] spd,
                            logic [CfgWidth-1:0] lim);
      wait_idle();
      write_reg(RegMass, m);
      write_reg(RegSpeed, spd);
      write_reg(RegLimit, lim);
      csr_we <= 1'b0;
   endtask

   // one beat on the request channel; valid stays up between back-to-back
   // beats of a burst and may drop for a random gap at the end of a burst
   task automatic send(logic [1:0] func, logic signed [31:0] x, logic signed [31:0] y,
                       logic signed [31:0] z, logic [DtWidth-1:0] dt);
      motion_req_type r;
      int unsigned gap;
      r.func = func;
      r.vec_x = x;
      r.vec_y = y;
      r.vec_z = z;
      r.dt = dt;
      req_ch.valid <= 1'b1;
      req_ch.payload <= r;
      do @(posedge clock); while (!(req_ch.valid && req_ch.ready));
      items_sent++;
      if (burst_left == 0) begin
         burst_left = $urandom_range(1, 8);
         gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 800);
         if (gap != 0) begin
            req_ch.valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
      end else begin
         burst_left--;
      end
   endtask

   task automatic drop_valid();
      req_ch.valid <= 1'b0;
      @(posedge clock);
   endtask

   function automatic logic signed [31:0] rand_val();
      case ($urandom_range(0, 5))
         0: return $urandom;
         1: return $signed($urandom_range(0, 32'hFFFFF)) - 32'sh80000;
         2: return $signed($urandom_range(0, 32'h3FFFFFF)) - 32'sh2000000;
         3: return ($urandom_range(0, 1) == 1) ? 32'sh7FFFFFFF : 32'sh80000000;
         4: return 0;
         default: return $signed($urandom_range(0, 32'h1FFFFFFF)) - 32'sh10000000;
      endcase
   endfunction

   function automatic logic [DtWidth-1:0] rand_dt();
      case ($urandom_range(0, 4))
         0: return 24'($urandom_range(0, 24'hFFFFFF));
         1: return 24'hFFFFFF;
         default: return 24'($urandom_range(0, 24'h2FFFF));
      endcase
   endfunction

   function automatic logic [CfgWidth-1:0] rand_reg();
      case ($urandom_range(0, 4))
         0: return 31'h7FFFFFFF;
         1: return 31'($urandom_range(0, 31'h7FFFFFFF));
         2: return 31'($urandom_range(0, 31'h3FFFFF));
         3: return 31'($urandom_range(0, 31'h7FFFFFF));
         default: return 31'($urandom_range(1, 31'h3FFFF));
      endcase
   endfunction

   int unsigned phase_items;
   int unsigned sel;

   initial begin
      reset = 1'b1;
      csr_we = 1'b0;
      csr_index = RegMass;
      csr_wdata = '0;
      req_ch.valid = 1'b0;
      req_ch.payload = '0;
      rsp_ch.ready = 1'b0;
      stall_run = 0;
      stall_pct = 0;
      burst_left = 0;
      items_sent = 0;
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed: reset defaults first, every operation and the unused code
      send(FuncNone, 32'sh7FFFFFFF, 32'sh80000000, -1, 24'hFFFFFF);
      send(FuncStep, 0, 0, 0, 24'h010000);                      // zero speed holds heading
      send(FuncStep, 32'sh00010000, 0, 0, 24'h010000);
      send(FuncStep, 32'sh7FFFFFFF, 32'sh7FFFFFFF, 32'sh7FFFFFFF, 24'hFFFFFF); // clamp
      send(FuncLoadVel, 32'sh7FFFFFFF, 32'sh80000000, 32'sh7FFFFFFF, 0);
      send(FuncStep, 32'sh7FFFFFFF, 32'sh80000000, 32'sh80000000, 24'hFFFFFF); // saturate
      send(FuncLoadPos, 32'sh7FFFFFFF, 32'sh80000000, 0, 24'hFFFFFF); // outside the cube
      send(FuncLoadVel, 0, 0, 0, 0);
      send(FuncStep, 0, 0, 0, 0);                               // loaded position wraps
      send(FuncLoadVel, 32'sh00640000, 32'shFF9C0000, 32'sh00000010, 0);
      send(FuncStep, 0, 0, 0, 24'hFFFFFF);
      send(FuncLoadVel, 5, -5, 3, 0);                           // speed under epsilon
      send(FuncStep, 0, 0, 0, 24'h000100);
      drop_valid();

      // zero mass, zero speed limit, zero world
      configure(31'd0, 31'd0, 31'd0);
      send(FuncStep, 32'sh00000001, -1, 0, 24'h000001);
      send(FuncLoadVel, 32'sh00010000, 0, 0, 0);
      send(FuncStep, 0, 0, 0, 24'h010000);
      send(FuncLoadPos, 1, -1, 0, 0);
      send(FuncStep, 0, 0, 0, 24'h010000);
      drop_valid();

      // every register at its top
      configure(31'h7FFFFFFF, 31'h7FFFFFFF, 31'h7FFFFFFF);
      send(FuncStep, 32'sh7FFFFFFF, 32'sh80000000, 32'sh12345678, 24'hFFFFFF);
      send(FuncLoadVel, 32'sh7FFFFFFF, 32'sh7FFFFFFF, 32'sh7FFFFFFF, 0);
      send(FuncStep, 32'sh80000000, 32'sh80000000, 32'sh80000000, 24'hFFFFFF);
      send(FuncLoadPos, 32'sh80000000, 32'sh7FFFFFFF, 32'sh80000000, 0);
      send(FuncStep, 0, 0, 0, 24'hFFFFFF);
      drop_valid();

      // random phases, each with its own register setting
      for (int ph = 0; ph < 8; ph++) begin
         configure(($urandom_range(0, 9) == 0) ? 31'd0 : rand_reg(), rand_reg(),
                   ($urandom_range(0, 9) == 0) ? 31'd0 : rand_reg());
         phase_items = $urandom_range(40, 60);
         for (int n = 0; n < phase_items; n++) begin
            sel = $urandom_range(0, 99);
            if (sel < 70)
               send(FuncStep, rand_val(), rand_val(), rand_val(), rand_dt());
            else if (sel < 82)
               send(FuncLoadVel, rand_val(), rand_val(), rand_val(), rand_dt());
            else if (sel < 95)
               send(FuncLoadPos, rand_val(), rand_val(), rand_val(), rand_dt());
            else
               send(FuncNone, rand_val(), rand_val(), rand_val(), rand_dt());
         end
         drop_valid();
      end

      // drain, then let the block settle before judging
      while (board.expected_beats.size() != 0) @(posedge clock);
      repeat (SettleCycles) @(posedge clock);

      $display("%0d beats sent: %0d steps, %0d loads, %0d clamped, %0d wrapped",
               items_sent, board.steps_seen, board.loads_seen, board.clamps_seen,
               board.wraps_seen);
      $display("register settings covered zero and full scale on every register");
      if (board.errors == 0) begin
         $display("ALL CHECKS PASSED");
      end else begin
         $display("%0d mismatches", board.errors);
         $display("CHECKS FAILED");
      end
      $finish;
   end

   // watchdog: well beyond the slowest legal run
   initial begin
      #40ms;
      $display("timeout with %0d beats outstanding", board.expected_beats.size());
      $display("CHECKS FAILED");
      $finish;
   end
endmodule
